// File: rtl/av1p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types, widths and constants of the av1 rtp payload packetizer
// no dependencies; the core, result queue and top rtl files import this package

package av1p_pkg;

   // field widths
   localparam int SIZE_W = 14;   // usable size, packet fill, chunk count
   localparam int LEN_W  = 21;   // obu length and obu bytes left
   localparam int MAX_RES = 7;   // most results one item can cause
   localparam int CNT_W  = 3;    // result count of one item

   // usable size limits and reset value
   localparam logic [SIZE_W-1:0] U_LOW   = SIZE_W'(128);
   localparam logic [SIZE_W-1:0] U_HIGH  = SIZE_W'(9000);
   localparam logic [SIZE_W-1:0] U_RESET = SIZE_W'(1196);

   // obu type of a temporal delimiter, which is dropped
   localparam logic [3:0] OBU_TYPE_TD = 4'd2;

   // one input item
   typedef struct packed {
      logic [7:0]       data_byte;
      logic             byte_valid;
      logic             obu_start;
      logic [3:0]       obu_type;
      logic [2:0]       temporal_id;
      logic [1:0]       spatial_id;
      logic [LEN_W-1:0] obu_length;
      logic             frame_start;
      logic             new_sequence;
      logic             frame_end;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       packet_end;
      logic       frame_marker;
      logic       y_flag;
      logic       run_last;
   } rsp_item_type;

   // all results of one input item, in order from entry 0
   typedef struct packed {
      rsp_item_type [MAX_RES-1:0] ent;
      logic [CNT_W-1:0]           count;
   } rsp_group_type;

   // handshake between the step logic and the result queue
   typedef struct packed {
      logic load;   // step logic hands over a group
   } grp_ctrl_type;

   function automatic rsp_item_type mk_item(input logic [7:0] b, input logic v,
                                            input logic pe, input logic fm,
                                            input logic y);
      rsp_item_type r;
      r.out_byte     = b;
      r.out_valid    = v;
      r.packet_end   = pe;
      r.frame_marker = fm;
      r.y_flag       = y;
      r.run_last     = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/av1p_if.sv
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces for the packetizer input and result streams
// no dependencies

interface av1p_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        byte_valid;
   logic        obu_start;
   logic [3:0]  obu_type;
   logic [2:0]  temporal_id;
   logic [1:0]  spatial_id;
   logic [20:0] obu_length;
   logic        frame_start;
   logic        new_sequence;
   logic        frame_end;

   modport source (
      output valid, data_byte, byte_valid, obu_start, obu_type, temporal_id,
             spatial_id, obu_length, frame_start, new_sequence, frame_end,
      input  ready
   );
   modport sink (
      input  valid, data_byte, byte_valid, obu_start, obu_type, temporal_id,
             spatial_id, obu_length, frame_start, new_sequence, frame_end,
      output ready
   );
endinterface

interface av1p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       packet_end;
   logic       frame_marker;
   logic       y_flag;
   logic       run_last;

   modport source (
      output valid, out_byte, out_valid, packet_end, frame_marker, y_flag, run_last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, out_valid, packet_end, frame_marker, y_flag, run_last,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/av1p_core.sv
`timescale 1ns / 1ps
`default_nettype none
// packetizer step logic: packet and obu state plus the result group of one item
// depends on av1p_pkg

module av1p_core #(
   parameter int unsigned MAX_OBU_BYTES = 1048576,
   parameter int unsigned CLOSE_MARGIN  = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   input  av1p_pkg::grp_ctrl_type        ctrl,
   input  av1p_pkg::req_item_type        item,
   input  logic [av1p_pkg::SIZE_W-1:0]   usable_bytes,
   output av1p_pkg::rsp_group_type       group
);
   import av1p_pkg::*;

   // length clamp and close margin at field width
   localparam bit CLAMP_LEN = MAX_OBU_BYTES < (64'd1 << LEN_W);
   localparam logic [LEN_W-1:0] MAX_LEN = CLAMP_LEN ? LEN_W'(MAX_OBU_BYTES) : '1;
   localparam logic [SIZE_W:0]  MARGIN  = (SIZE_W+1)'(CLOSE_MARGIN);

   // state
   logic [SIZE_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  obu_left_ff, obu_left_in;
   logic [SIZE_W-1:0] chunk_left_ff, chunk_left_in;
   logic              cont_ff, cont_in;
   logic              seq_ff, seq_in;
   logic              first_ff, first_in;
   logic              drop_ff, drop_in;
   logic [3:0]        otype_ff, otype_in;
   logic [2:0]        tid_ff, tid_in;
   logic [1:0]        sid_ff, sid_in;

   // step intermediates
   logic [SIZE_W-1:0] u;
   logic [SIZE_W-1:0] fill0, fill_h, room, w, size, chunk_eff;
   logic [LEN_W-1:0]  len, left1;
   logic [SIZE_W-1:0] chunk1;
   logic              cont0, first1, drop1, ext;
   logic              mark_fs, need_hdr, close, open, data_emit, split, bare_end, leb2;
   logic [CNT_W-1:0]  n;
   rsp_group_type     grp;

   // one item through the packetizer rules
   always_comb begin
      // usable size clamp
      u = usable_bytes;
      if (u < U_LOW) begin
         u = U_LOW;
      end else if (u > U_HIGH) begin
         u = U_HIGH;
      end

      // frame start closes the open packet and clears obu state
      mark_fs = item.frame_start && (fill_ff != '0);
      fill0   = item.frame_start ? '0 : fill_ff;
      cont0   = item.frame_start ? 1'b0 : cont_ff;
      seq_in  = item.frame_start ? item.new_sequence : seq_ff;
      left1   = item.frame_start ? '0 : obu_left_ff;
      chunk1  = item.frame_start ? '0 : chunk_left_ff;
      first1  = item.frame_start ? 1'b0 : first_ff;
      drop1   = item.frame_start ? 1'b0 : drop_ff;
      otype_in = otype_ff;
      tid_in   = tid_ff;
      sid_in   = sid_ff;

      // new obu
      len = (item.obu_length == '0) ? LEN_W'(1) : item.obu_length;
      if (len > MAX_LEN) begin
         len = MAX_LEN;
      end
      if (item.byte_valid && item.obu_start) begin
         left1    = len;
         chunk1   = '0;
         first1   = 1'b1;
         drop1    = (item.obu_type == OBU_TYPE_TD);
         otype_in = item.obu_type;
         tid_in   = item.temporal_id;
         sid_in   = item.spatial_id;
      end
      ext = (tid_in != '0) || (sid_in != '0);

      // defaults
      obu_left_in   = left1;
      chunk_left_in = chunk1;
      first_in      = first1;
      drop_in       = drop1;
      fill_in       = fill0;
      cont_in       = cont0;
      need_hdr      = 1'b0;
      close         = 1'b0;
      open          = 1'b0;
      data_emit     = 1'b0;
      split         = 1'b0;
      leb2          = 1'b0;
      room          = '0;
      w             = '0;
      size          = '0;
      fill_h        = fill0;
      chunk_eff     = chunk1;

      // payload byte
      if (item.byte_valid && (left1 != '0)) begin
         obu_left_in = left1 - 1'b1;
         if (drop1) begin
            drop_in = (obu_left_in != '0);
         end else begin
            data_emit = 1'b1;
            need_hdr  = (chunk1 == '0);
            if (need_hdr) begin
               // close a nearly full packet, then size the new element
               close = (fill0 != '0) && !(({1'b0, fill0} + MARGIN) < {1'b0, u});
               open  = (fill0 == '0) || close;
               room  = open ? u : u - fill0;
               w     = (left1 < LEN_W'(room)) ? left1[SIZE_W-1:0] : room;
               size  = first1 ? w + SIZE_W'(1) + SIZE_W'(ext) : w;
               leb2  = (size[SIZE_W-1:7] != '0);
               fill_h = (open ? SIZE_W'(1) : fill0) + (leb2 ? SIZE_W'(2) : SIZE_W'(1))
                        + (first1 ? (ext ? SIZE_W'(2) : SIZE_W'(1)) : SIZE_W'(0));
               chunk_eff = w;
               first_in  = 1'b0;
               if (open) begin
                  seq_in = 1'b0;
               end
            end
            chunk_left_in = chunk_eff - 1'b1;
            fill_in       = fill_h + 1'b1;
            split         = (chunk_left_in == '0) && (obu_left_in != '0);
            if (split) begin
               cont_in = 1'b1;
               fill_in = '0;
            end else if (chunk_left_in == '0) begin
               cont_in = 1'b0;
            end
         end
      end

      // frame end closes the packet and abandons the obu
      bare_end = item.frame_end && !data_emit && (fill0 != '0);
      if (item.frame_end) begin
         fill_in       = '0;
         obu_left_in   = '0;
         chunk_left_in = '0;
         drop_in       = 1'b0;
         first_in      = 1'b0;
      end

      // result group in emission order
      grp = '0;
      n   = '0;
      if (mark_fs) begin
         grp.ent[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
         n = n + 1'b1;
      end
      if (close) begin
         grp.ent[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
         n = n + 1'b1;
      end
      if (open) begin
         grp.ent[n] = mk_item({cont0, 3'b000, seq_ff & ~item.frame_start
                               | item.frame_start & item.new_sequence, 3'b000},
                              1'b1, 1'b0, 1'b0, 1'b0);
         n = n + 1'b1;
      end
      if (need_hdr) begin
         grp.ent[n] = mk_item({leb2, size[6:0]}, 1'b1, 1'b0, 1'b0, 1'b0);
         n = n + 1'b1;
         if (leb2) begin
            grp.ent[n] = mk_item({1'b0, size[SIZE_W-1:7]}, 1'b1, 1'b0, 1'b0, 1'b0);
            n = n + 1'b1;
         end
         if (first1) begin
            grp.ent[n] = mk_item({1'b0, otype_in, ext, 2'b00}, 1'b1, 1'b0, 1'b0, 1'b0);
            n = n + 1'b1;
            if (ext) begin
               grp.ent[n] = mk_item({tid_in, sid_in, 3'b000}, 1'b1, 1'b0, 1'b0, 1'b0);
               n = n + 1'b1;
            end
         end
      end
      if (data_emit) begin
         grp.ent[n] = mk_item(item.data_byte, 1'b1, split || item.frame_end,
                              item.frame_end && !split, split);
         n = n + 1'b1;
      end
      if (bare_end) begin
         grp.ent[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
         n = n + 1'b1;
      end
      if (n != '0) begin
         grp.ent[n - 1'b1].run_last = 1'b1;
      end
      grp.count = n;
   end

   assign group = grp;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         obu_left_ff   <= '0;
         chunk_left_ff <= '0;
         cont_ff       <= 1'b0;
         seq_ff        <= 1'b0;
         first_ff      <= 1'b0;
         drop_ff       <= 1'b0;
         otype_ff      <= '0;
         tid_ff        <= '0;
         sid_ff        <= '0;
      end else if (ctrl.load) begin
         fill_ff       <= fill_in;
         obu_left_ff   <= obu_left_in;
         chunk_left_ff <= chunk_left_in;
         cont_ff       <= cont_in;
         seq_ff        <= seq_in;
         first_ff      <= first_in;
         drop_ff       <= drop_in;
         otype_ff      <= otype_in;
         tid_ff        <= tid_in;
         sid_ff        <= sid_in;
      end
   end

   // a split close leaves the next packet marked as a continuation
   a_split_sets_cont: assert property (@(posedge clock) disable iff (reset)
      ctrl.load && split |=> cont_ff)
      else $error("continuation not set after split close");

   // frame end leaves no obu in progress
   a_fend_clears_obu: assert property (@(posedge clock) disable iff (reset)
      ctrl.load && item.frame_end |=> (obu_left_ff == '0) && (chunk_left_ff == '0))
      else $error("obu state kept across frame end");

   // packet fill stays within the largest usable size plus header bytes
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= U_HIGH + SIZE_W'(5))
      else $error("packet fill out of range");

endmodule

`default_nettype wire

// File: rtl/av1p_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// result queue: holds the result group of one item and shifts it out one per cycle while rsp_ready is high
// depends on av1p_pkg

module av1p_outq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_req,
   input  av1p_pkg::rsp_group_type group,
   output av1p_pkg::grp_ctrl_type  ctrl,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output av1p_pkg::rsp_item_type  rsp_item
);
   import av1p_pkg::*;

   rsp_item_type [MAX_RES-1:0] ent_ff, ent_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       take;
   logic                       free;

   // free when empty or the last result leaves now
   assign take = (cnt_ff != '0) && rsp_ready;
   assign free = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_ready);

   assign ctrl.load = load_req && free;

   // load a new group or shift toward entry 0
   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         ent_in = group.ent;
         cnt_in = group.count;
      end else if (take) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            ent_in[i] = ent_ff[i + 1];
         end
         cnt_in = cnt_ff - 1'b1;
      end else if (free) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = ent_ff[0];

   // the last queued result closes its item
   a_last_has_run_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(1)) |-> ent_ff[0].run_last)
      else $error("last result of item lacks run_last");

   // earlier results of an item do not
   a_early_no_run_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > CNT_W'(1)) |-> !ent_ff[0].run_last)
      else $error("run_last before the end of the item");

   // a result without a byte is always a packet close
   a_bare_is_close: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && !ent_ff[0].out_valid |-> ent_ff[0].packet_end)
      else $error("bare result that does not close a packet");

endmodule

`default_nettype wire

// File: rtl/av1_rtp_payload_packetizer.sv
`timescale 1ns / 1ps
`default_nettype none
// av1 rtp payload packetizer top: input register, size register, step logic, result queue
// depends on av1p_pkg, av1p_if, av1p_core, av1p_outq
// an item waits in the input register; its results (0 to 7) are offered from the queue
// throughput: one item per cycle while no item has over one result and rsp is ready
// reset: synchronous, active high; clears all packet and obu state, empties both
//   stages and sets the usable size to 1196

module av1_rtp_payload_packetizer #(
   parameter int unsigned MAX_OBU_BYTES = 1048576,
   parameter int unsigned CLOSE_MARGIN  = 100
) (
   input  logic                        clock,
   input  logic                        reset,
   av1p_req_if.sink                    req_chan,
   av1p_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [av1p_pkg::SIZE_W-1:0] csr_wr_data
);
   import av1p_pkg::*;

   logic              in_valid_ff, in_valid_in;
   req_item_type      in_item_ff, req_item;
   logic [SIZE_W-1:0] usable_ff;
   grp_ctrl_type      ctrl;
   rsp_group_type     group;
   rsp_item_type      rsp_item;
   logic              rsp_valid;
   logic              req_take;

   // input item from the channel
   always_comb begin
      req_item.data_byte    = req_chan.data_byte;
      req_item.byte_valid   = req_chan.byte_valid;
      req_item.obu_start    = req_chan.obu_start;
      req_item.obu_type     = req_chan.obu_type;
      req_item.temporal_id  = req_chan.temporal_id;
      req_item.spatial_id   = req_chan.spatial_id;
      req_item.obu_length   = req_chan.obu_length;
      req_item.frame_start  = req_chan.frame_start;
      req_item.new_sequence = req_chan.new_sequence;
      req_item.frame_end    = req_chan.frame_end;
   end

   // input register takes a new item when empty or handing over
   assign req_chan.ready = !in_valid_ff || ctrl.load;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (ctrl.load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   // usable size register
   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= U_RESET;
      end else if (csr_wr_en) begin
         usable_ff <= csr_wr_data;
      end
   end

   av1p_core #(
      .MAX_OBU_BYTES (MAX_OBU_BYTES),
      .CLOSE_MARGIN  (CLOSE_MARGIN)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .item         (in_item_ff),
      .usable_bytes (usable_ff),
      .group        (group)
   );

   av1p_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .load_req  (in_valid_ff),
      .group     (group),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   // result channel
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.out_byte     = rsp_item.out_byte;
   assign rsp_chan.out_valid    = rsp_item.out_valid;
   assign rsp_chan.packet_end   = rsp_item.packet_end;
   assign rsp_chan.frame_marker = rsp_item.frame_marker;
   assign rsp_chan.y_flag       = rsp_item.y_flag;
   assign rsp_chan.run_last     = rsp_item.run_last;

endmodule

`default_nettype wire
